// File: sv/page_lcd_number_renderer_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the page LCD number renderer
// Clocked assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef PAGE_LCD_NUMBER_RENDERER_UNIT_DEFINES_SVH
`define PAGE_LCD_NUMBER_RENDERER_UNIT_DEFINES_SVH

// property checked on every rising edge, masked while reset is high
`define PLNR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// property checked on every rising edge, reset included
`define PLNR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/plnr_pkg.sv
// ---------------------------------------------------------------------------
// plnr_pkg
// Shared types, codes, glyph ROM and constants of the page LCD renderer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plnr_pkg;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_NUMBER = 2'd1,
      CMD_SYMBOL = 2'd2,
      CMD_EMIT   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EMIT,
      ST_DIV,
      ST_DIGIT,
      ST_SIGN,
      ST_PAINT
   } state_type;

   // configuration port
   localparam int          CSR_ADDR_W         = 3;
   localparam logic        REG_START_COLUMN   = 1'b0;
   localparam logic [7:0]  START_COLUMN_RESET = 8'd30;

   // panel command bytes
   localparam logic [7:0]  PANEL_CMD_PAGE     = 8'hB0;
   localparam logic [7:0]  PANEL_CMD_COL_LOW  = 8'h00;
   localparam logic [7:0]  PANEL_CMD_COL_HIGH = 8'h10;

   // divide by ten: q = (v * 52429) >> 19, exact for v below 43690
   localparam logic [15:0] DIV10_RECIP = 16'd52429;
   localparam int          DIV10_SHIFT = 19;

   localparam int          GLYPH_COUNT = 12;
   localparam int          GLYPH_COLS  = 9;
   localparam logic [3:0]  GLYPH_PLUS  = 4'd0;
   localparam logic [3:0]  GLYPH_MINUS = 4'd1;
   localparam logic [3:0]  GLYPH_ZERO  = 4'd2;

   localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
      '{8'h00, 8'h00, 8'h00, 8'h20, 8'h70, 8'h20, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hF0, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'hF0},
      '{8'h20, 8'h60, 8'hA0, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'hF0},
      '{8'hF0, 8'h90, 8'h10, 8'h10, 8'h10, 8'h20, 8'h40, 8'h80, 8'hF0},
      '{8'hF0, 8'h10, 8'h10, 8'h10, 8'hF0, 8'h10, 8'h10, 8'h10, 8'hF0},
      '{8'h90, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'h10, 8'h10},
      '{8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'h10, 8'h10, 8'h10, 8'hF0},
      '{8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0},
      '{8'hF0, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10},
      '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0},
      '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'h10, 8'hF0}
   };

   // map an ASCII code to a ROM index; bit 4 flags a hit
   function automatic logic [4:0] glyph_find(input logic [7:0] code);
      logic [4:0] res;
      res = 5'd0;
      if (code == 8'h2B) begin
         res = {1'b1, GLYPH_PLUS};
      end else if (code == 8'h2D) begin
         res = {1'b1, GLYPH_MINUS};
      end else if (code >= 8'h30 && code <= 8'h39) begin
         res = {1'b1, 4'(code[3:0] + GLYPH_ZERO)};
      end
      return res;
   endfunction

   // one column byte of a glyph; columns past the ROM width are blank
   function automatic logic [7:0] glyph_column(input logic [3:0] idx, input logic [3:0] col);
      logic [7:0] res;
      res = 8'h00;
      if (int'(idx) < GLYPH_COUNT && int'(col) < GLYPH_COLS) begin
         res = GLYPH_ROM[idx][col];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: sv/plnr_if.sv
// ---------------------------------------------------------------------------
// plnr_if
// Valid/ready channels for renderer commands and refresh stream bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface plnr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [15:0] number;
   logic [7:0]         char_code;
   logic [3:0]         page_index;
   logic [6:0]         column_shift;

   modport source (
      output valid, command, number, char_code, page_index, column_shift,
      input  ready
   );
   modport sink (
      input  valid, command, number, char_code, page_index, column_shift,
      output ready
   );
endinterface

interface plnr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_data;
   logic       frame_end;

   modport source (
      output valid, out_byte, is_data, frame_end,
      input  ready
   );
   modport sink (
      input  valid, out_byte, is_data, frame_end,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/page_lcd_number_renderer_unit.sv
// ---------------------------------------------------------------------------
// page_lcd_number_renderer_unit
// Page-organised frame store with glyph painter and panel refresh stream.
// Commands arrive on req_if (valid/ready); only emit produces a byte on
// rsp_if. The store is a 2**(page bits + column bits) byte RAM, read and
// written back one glyph column per cycle.
// Per item: draw symbol paints GLYPH_WIDTH glyph columns; draw number runs
// the ST_DIV and ST_DIGIT steps and paints one glyph per digit, then paints
// the sign; clear writes every RAM word. The RAM port takes one word a cycle.
// An emit goes to ST_EMIT, which registers its byte once the output is free.
// Reset runs the same clearing sweep with req_if.ready low; the APB port
// takes writes throughout.
// A result waits in the output register while rsp_if.ready is low; draw
// and clear items are still taken meanwhile, a further emit waits for it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module page_lcd_number_renderer_unit #(
   parameter int PAGES       = 8,
   parameter int COLUMNS     = 102,
   parameter int GLYPH_WIDTH = 9
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   plnr_req_if.sink                             req_if,
   plnr_rsp_if.source                           rsp_if,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [plnr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready
);
   import plnr_pkg::*;

   localparam int PW        = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int CW        = $clog2(COLUMNS);
   localparam int AW        = PW + CW;
   localparam int DEPTH     = 1 << AW;
   localparam int SW        = $clog2(COLUMNS + 2);
   localparam int LAST_SLOT = COLUMNS + 1;
   localparam int IW        = $clog2(GLYPH_WIDTH + 1);
   localparam int TW        = ((CW > 7) ? CW : 7) + 2;

   // -------------------------------------------------------------------
   // configuration
   // -------------------------------------------------------------------
   logic [7:0] start_column;

   plnr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .start_column (start_column)
   );

   // -------------------------------------------------------------------
   // frame store
   // -------------------------------------------------------------------
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;

   plnr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // -------------------------------------------------------------------
   // registers
   // -------------------------------------------------------------------
   state_type     state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [PW-1:0] stream_page_ff, stream_page_in;
   logic [SW-1:0] stream_slot_ff, stream_slot_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [7:0]    wr_bits_ff, wr_bits_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_data_ff, rsp_data_in;
   logic          rsp_end_ff, rsp_end_in;

   logic [3:0]    glyph_ff, glyph_in;
   logic [PW-1:0] page_ff, page_in;
   logic [6:0]    shift_ff, shift_in;
   logic [IW-1:0] col_idx_ff, col_idx_in;
   logic          paint_last_ff, paint_last_in;
   logic [15:0]   mag_ff, mag_in;
   logic [11:0]   quot_ff, quot_in;
   logic          neg_ff, neg_in;
   logic [2:0]    digit_cnt_ff, digit_cnt_in;

   // -------------------------------------------------------------------
   // datapath helpers
   // -------------------------------------------------------------------
   logic          req_fire;
   logic [4:0]    sym_hit;
   logic [15:0]   num_raw;
   logic [31:0]   div_prod;
   logic [15:0]   quot_x10;
   logic [3:0]    digit;
   logic [TW-1:0] target_col;
   logic [CW-1:0] emit_col;
   logic          emit_is_data;
   logic          digit_page_ok;

   assign req_if.ready = (state_ff == ST_IDLE) && !wr_pend_ff;
   assign req_fire     = req_if.valid && req_if.ready;

   assign sym_hit    = glyph_find(req_if.char_code);
   assign num_raw    = req_if.number;
   assign div_prod   = 32'(mag_ff) * 32'(DIV10_RECIP);
   assign quot_x10   = {1'b0, quot_ff, 3'b000} + {3'b000, quot_ff, 1'b0};
   assign digit      = 4'(mag_ff - quot_x10);
   // may wrap below zero; the top bit then marks a column off the left edge
   assign target_col = TW'(COLUMNS - 1) - TW'(col_idx_ff) - TW'(shift_ff);
   assign emit_col   = CW'(COLUMNS + 2 - int'(stream_slot_ff));
   assign emit_is_data  = (int'(stream_slot_ff) >= 3);
   assign digit_page_ok = (int'(digit_cnt_ff) < PAGES);

   // write port: clearing sweep or the write-back half of a paint
   always_comb begin
      mem_wr_en   = wr_pend_ff;
      mem_wr_addr = wr_addr_ff;
      mem_wr_data = mem_rd_data | wr_bits_ff;
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = 8'h00;
      end
   end

   // -------------------------------------------------------------------
   // sequencer
   // -------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      stream_page_in = stream_page_ff;
      stream_slot_in = stream_slot_ff;
      wr_pend_in     = 1'b0;
      wr_addr_in     = wr_addr_ff;
      wr_bits_in     = wr_bits_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_end_in     = rsp_end_ff;
      glyph_in       = glyph_ff;
      page_in        = page_ff;
      shift_in       = shift_ff;
      col_idx_in     = col_idx_ff;
      paint_last_in  = paint_last_ff;
      mag_in         = mag_ff;
      quot_in        = quot_ff;
      neg_in         = neg_ff;
      digit_cnt_in   = digit_cnt_ff;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = {stream_page_ff, emit_col};

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               unique case (cmd_type'(req_if.command))
                  CMD_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  CMD_NUMBER: begin
                     neg_in       = num_raw[15];
                     mag_in       = num_raw[15] ? 16'(-num_raw) : num_raw;
                     digit_cnt_in = 3'd0;
                     state_in     = ST_DIV;
                  end
                  CMD_SYMBOL: begin
                     // drop unknown codes and pages off the panel
                     if (sym_hit[4] && int'(req_if.page_index) < PAGES) begin
                        glyph_in      = sym_hit[3:0];
                        page_in       = PW'(req_if.page_index);
                        shift_in      = req_if.column_shift;
                        col_idx_in    = '0;
                        paint_last_in = 1'b1;
                        state_in      = ST_PAINT;
                     end
                  end
                  CMD_EMIT: begin
                     mem_rd_en = emit_is_data;
                     state_in  = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 1'b0;
               rsp_end_in   = 1'b0;
               priority if (stream_slot_ff == SW'(0)) begin
                  rsp_byte_in = PANEL_CMD_PAGE |
                                {4'h0, 4'(PAGES - 1 - int'(stream_page_ff))};
               end else if (stream_slot_ff == SW'(1)) begin
                  rsp_byte_in = PANEL_CMD_COL_LOW | {4'h0, start_column[3:0]};
               end else if (stream_slot_ff == SW'(2)) begin
                  rsp_byte_in = PANEL_CMD_COL_HIGH | {4'h0, start_column[7:4]};
               end else begin
                  rsp_byte_in = mem_rd_data;
                  rsp_data_in = 1'b1;
               end
               // advance the refresh cursor, wrap after the last page
               if (stream_slot_ff == SW'(LAST_SLOT)) begin
                  stream_slot_in = '0;
                  if (stream_page_ff == PW'(PAGES - 1)) begin
                     stream_page_in = '0;
                     rsp_end_in     = 1'b1;
                  end else begin
                     stream_page_in = stream_page_ff + PW'(1);
                  end
               end else begin
                  stream_slot_in = stream_slot_ff + SW'(1);
               end
               state_in = ST_IDLE;
            end
         end

         ST_DIV: begin
            quot_in  = div_prod[DIV10_SHIFT+11:DIV10_SHIFT];
            state_in = ST_DIGIT;
         end

         ST_DIGIT: begin
            glyph_in      = 4'(digit + GLYPH_ZERO);
            page_in       = PW'(PAGES - 1 - int'(digit_cnt_ff));
            shift_in      = 7'd0;
            col_idx_in    = '0;
            paint_last_in = 1'b0;
            mag_in        = 16'(quot_ff);
            digit_cnt_in  = digit_cnt_ff + 3'd1;
            if (digit_page_ok) begin
               state_in = ST_PAINT;
            end else if (quot_ff == 12'd0) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIV;
            end
         end

         ST_SIGN: begin
            glyph_in      = neg_ff ? GLYPH_MINUS : GLYPH_PLUS;
            page_in       = PW'(PAGES - 1 - int'(digit_cnt_ff));
            shift_in      = 7'd0;
            col_idx_in    = '0;
            paint_last_in = 1'b1;
            state_in      = digit_page_ok ? ST_PAINT : ST_IDLE;
         end

         ST_PAINT: begin
            // read one column now, OR the glyph in and write it next cycle
            if (!target_col[TW-1]) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = {page_ff, target_col[CW-1:0]};
               wr_pend_in  = 1'b1;
               wr_addr_in  = {page_ff, target_col[CW-1:0]};
               wr_bits_in  = glyph_column(glyph_ff, 4'(col_idx_ff));
            end
            col_idx_in = col_idx_ff + IW'(1);
            if (col_idx_ff == IW'(GLYPH_WIDTH - 1)) begin
               if (paint_last_ff) begin
                  state_in = ST_IDLE;
               end else if (mag_ff == 16'd0) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         stream_page_ff <= '0;
         stream_slot_ff <= '0;
         wr_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         stream_page_ff <= stream_page_in;
         stream_slot_ff <= stream_slot_in;
         wr_pend_ff     <= wr_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff    <= wr_addr_in;
      wr_bits_ff    <= wr_bits_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_end_ff    <= rsp_end_in;
      glyph_ff      <= glyph_in;
      page_ff       <= page_in;
      shift_ff      <= shift_in;
      col_idx_ff    <= col_idx_in;
      paint_last_ff <= paint_last_in;
      mag_ff        <= mag_in;
      quot_ff       <= quot_in;
      neg_ff        <= neg_in;
      digit_cnt_ff  <= digit_cnt_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_byte  = rsp_byte_ff;
   assign rsp_if.is_data   = rsp_data_ff;
   assign rsp_if.frame_end = rsp_end_ff;

endmodule

`default_nettype wire

// File: sv/plnr_ram.sv
// ---------------------------------------------------------------------------
// plnr_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plnr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/plnr_csr.sv
// ---------------------------------------------------------------------------
// plnr_csr
// APB register slice holding the panel start column.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plnr_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [plnr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready,
   output logic      [7:0]                      start_column
);
   import plnr_pkg::*;

   logic [7:0] start_column_ff;
   logic [7:0] start_column_in;
   logic       hit;

   assign hit    = (paddr[CSR_ADDR_W-1] == REG_START_COLUMN);
   assign pready = 1'b1;

   always_comb begin
      start_column_in = start_column_ff;
      if (psel && penable && pwrite && hit) begin
         start_column_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_column_ff <= START_COLUMN_RESET;
      end else begin
         start_column_ff <= start_column_in;
      end
   end

   assign prdata       = hit ? {24'h000000, start_column_ff} : 32'h00000000;
   assign start_column = start_column_ff;

endmodule

`default_nettype wire

// File: sv/plnr_checker.sv
// ---------------------------------------------------------------------------
// plnr_checker
// Port-level checks of the renderer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "page_lcd_number_renderer_unit_defines.svh"

module plnr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_is_data,
   input wire logic       rsp_frame_end
);

   // a stalled item stays offered
   `PLNR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp item dropped while stalled")

   // the frame ends on a data byte, never on a command
   `PLNR_ASSERT(a_end_on_data, rsp_valid && rsp_frame_end |-> rsp_is_data, "frame end on command byte")

   // command bytes are page, column-low or column-high commands only
   `PLNR_ASSERT(a_cmd_kind, rsp_valid && !rsp_is_data |-> rsp_out_byte[7:4] == 4'hB || rsp_out_byte[7:4] == 4'h0 || rsp_out_byte[7:4] == 4'h1, "unknown panel command byte")

   // the store is being swept right after reset, so no item is taken
   `PLNR_ASSERT_ALWAYS(a_sweep_after_reset, $fell(reset) |-> !req_ready, "item taken during reset sweep")

endmodule

bind page_lcd_number_renderer_unit plnr_checker u_plnr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_out_byte  (rsp_if.out_byte),
   .rsp_is_data   (rsp_if.is_data),
   .rsp_frame_end (rsp_if.frame_end)
);

`default_nettype wire

// File: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the page LCD number renderer. A shadow frame store
// in the bench paints every accepted draw item and predicts each refresh
// byte; bytes on the result channel are checked in order, field by field.
// Directed items come first, then random draw items mixed with runs of emit
// items, with the start column changed over the APB port between phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import plnr_pkg::*;

   localparam int NUM_PAGES     = 8;
   localparam int NUM_COLS      = 102;
   localparam int FONT_WIDTH    = 9;
   localparam int LAST_SLOT     = NUM_COLS + 1;
   localparam int SETTLE_CYCLES = 1200;  // longer than a full clearing sweep
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_ITEMS   = 80;

   localparam logic [7:0] PAGE_CMD   = 8'hB0;
   localparam logic [7:0] COL_LO_CMD = 8'h00;
   localparam logic [7:0] COL_HI_CMD = 8'h10;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] COL_RESET  = 8'd30;

   localparam logic [CSR_ADDR_W-1:0] START_COL_ADDR = CSR_ADDR_W'(4 * int'(REG_START_COLUMN));

   // '+', '-', then '0'..'9'
   localparam logic [7:0] FONT_BITS [12][9] = '{
      '{8'h00, 8'h00, 8'h00, 8'h20, 8'h70, 8'h20, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hF0, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'hF0},
      '{8'h20, 8'h60, 8'hA0, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'hF0},
      '{8'hF0, 8'h90, 8'h10, 8'h10, 8'h10, 8'h20, 8'h40, 8'h80, 8'hF0},
      '{8'hF0, 8'h10, 8'h10, 8'h10, 8'hF0, 8'h10, 8'h10, 8'h10, 8'hF0},
      '{8'h90, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'h10, 8'h10},
      '{8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'h10, 8'h10, 8'h10, 8'hF0},
      '{8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0},
      '{8'hF0, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10},
      '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0},
      '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'h10, 8'hF0}
   };

   typedef struct {
      cmd_type            command;
      logic signed [15:0] number;
      logic [7:0]         char_code;
      logic [3:0]         page_index;
      logic [6:0]         column_shift;
   } lcd_item_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       is_data;
      logic       frame_end;
   } lcd_byte_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   plnr_req_if req_bus ();
   plnr_rsp_if rsp_bus ();

   page_lcd_number_renderer_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow of the frame store and refresh cursor
   logic [7:0]  panel_ram [NUM_PAGES][NUM_COLS];
   int unsigned scan_page    = 0;
   int unsigned scan_slot    = 0;
   logic [7:0]  col_addr_reg = COL_RESET;

   lcd_item_type cmd_backlog [$];
   lcd_byte_type bytes_due [$];

   int unsigned req_sent    = 0;
   int unsigned req_taken   = 0;
   int unsigned cycle_count = 0;
   int          err_count   = 0;
   int          tx_gap      = 0;
   int          rx_gap      = 0;
   int          tx_idle_pct = 10;
   int          rx_idle_pct = 10;
   bit          drv_busy    = 1'b0;
   bit          hold_go     = 1'b0;
   bit          rsp_hold    = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------- shadow renderer ----------------

   function automatic int font_index(input logic [7:0] code);
      if (code == CH_PLUS) return 0;
      if (code == CH_MINUS) return 1;
      if (code >= CH_ZERO && code <= CH_ZERO + 8'd9) return int'(code - CH_ZERO) + 2;
      return -1;
   endfunction

   function automatic void clear_panel();
      foreach (panel_ram[p, c]) panel_ram[p][c] = 8'h00;
   endfunction

   // mirrored: glyph column i lands left of the right edge; drop what falls off
   function automatic void paint_char(input logic [7:0] code, input int page, input int shift);
      int idx;
      int col;
      int i;
      idx = font_index(code);
      if (page < 0 || page >= NUM_PAGES || idx < 0) return;
      for (i = 0; i < FONT_WIDTH; i++) begin
         col = NUM_COLS - 1 - i - shift;
         if (col >= 0) panel_ram[page][col] |= FONT_BITS[idx][i];
      end
   endfunction

   function automatic void paint_value(input logic signed [15:0] value);
      int unsigned mag;
      int          n;
      logic        neg;
      neg = value[15];
      mag = 32'(value[15:0]);
      if (neg) mag = 32'd65536 - mag;
      n = 0;
      do begin
         paint_char(CH_ZERO + 8'(mag % 10), NUM_PAGES - 1 - n, 0);
         mag = mag / 10;
         n++;
      end while (mag != 0);
      paint_char(neg ? CH_MINUS : CH_PLUS, NUM_PAGES - 1 - n, 0);
   endfunction

   function automatic lcd_byte_type next_stream_byte();
      lcd_byte_type b;
      b.is_data   = 1'b0;
      b.frame_end = 1'b0;
      if (scan_slot == 0) begin
         b.out_byte = PAGE_CMD | 8'(NUM_PAGES - 1 - scan_page);
      end else if (scan_slot == 1) begin
         b.out_byte = COL_LO_CMD | {4'h0, col_addr_reg[3:0]};
      end else if (scan_slot == 2) begin
         b.out_byte = COL_HI_CMD | {4'h0, col_addr_reg[7:4]};
      end else begin
         b.out_byte = panel_ram[scan_page][NUM_COLS + 2 - scan_slot];
         b.is_data  = 1'b1;
      end
      if (scan_slot == LAST_SLOT) begin
         scan_slot = 0;
         if (scan_page == NUM_PAGES - 1) begin
            b.frame_end = 1'b1;
            scan_page   = 0;
         end else begin
            scan_page++;
         end
      end else begin
         scan_slot++;
      end
      return b;
   endfunction

   function automatic void apply_item(input lcd_item_type item);
      case (item.command)
         CMD_CLEAR: begin
            clear_panel();
         end
         CMD_NUMBER: begin
            paint_value(item.number);
         end
         CMD_SYMBOL: begin
            paint_char(item.char_code, int'(item.page_index), int'(item.column_shift));
         end
         CMD_EMIT: begin
            bytes_due.push_back(next_stream_byte());
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void check_field(input string label, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         err_count++;
         $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      end
   endfunction

   // ---------------- driver, receiver, monitor ----------------

   always @(negedge clock) begin
      lcd_item_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (drv_busy && req_taken == req_sent) drv_busy = 1'b0;
         if (!drv_busy) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_bus.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0 && $urandom_range(99, 0) < tx_idle_pct) begin
               tx_gap = $urandom_range(19, 1) - 1;
               req_bus.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               item = cmd_backlog.pop_front();
               req_bus.command      <= item.command;
               req_bus.number       <= item.number;
               req_bus.char_code    <= item.char_code;
               req_bus.page_index   <= item.page_index;
               req_bus.column_shift <= item.column_shift;
               req_bus.valid        <= 1'b1;
               drv_busy = 1'b1;
               req_sent++;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_bus.ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(99, 0) < rx_idle_pct) begin
         rx_gap = $urandom_range(19, 1) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // long receiver hold-off once emits are flowing; the sender keeps offering items
   initial begin
      wait (hold_go);
      while (bytes_due.size() == 0) @(posedge clock);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_hold = 1'b0;
   end

   always @(posedge clock) begin
      lcd_item_type taken;
      lcd_byte_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            taken.command      = cmd_type'(req_bus.command);
            taken.number       = req_bus.number;
            taken.char_code    = req_bus.char_code;
            taken.page_index   = req_bus.page_index;
            taken.column_shift = req_bus.column_shift;
            apply_item(taken);
            req_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (bytes_due.size() == 0) begin
               err_count++;
               $display("%0t: refresh byte expected none, got %0h", $time, rsp_bus.out_byte);
            end else begin
               want = bytes_due.pop_front();
               check_field("out_byte", want.out_byte, rsp_bus.out_byte);
               check_field("is_data", 8'(want.is_data), 8'(rsp_bus.is_data));
               check_field("frame_end", 8'(want.frame_end), 8'(rsp_bus.frame_end));
            end
         end
      end
   end

   // ---------------- stimulus ----------------

   function automatic void queue_cmd(input cmd_type cmd, input logic [15:0] num,
                                     input logic [7:0] ch, input logic [3:0] page,
                                     input logic [6:0] shift);
      lcd_item_type item;
      item.command      = cmd;
      item.number       = num;
      item.char_code    = ch;
      item.page_index   = page;
      item.column_shift = shift;
      cmd_backlog.push_back(item);
   endfunction

   // fields that the command ignores carry random bits
   function automatic void queue_plain(input cmd_type cmd);
      queue_cmd(cmd, 16'($urandom), 8'($urandom), 4'($urandom), 7'($urandom));
   endfunction

   function automatic logic [15:0] random_number();
      case ($urandom_range(4, 0))
         0: return 16'($urandom);
         1: return 16'($urandom_range(999, 0));
         2: return 16'(-int'($urandom_range(999, 0)));
         3: begin
            case ($urandom_range(5, 0))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h8001;
               3: return 16'h0000;
               4: return 16'hFFFF;
               default: return 16'd10000;
            endcase
         end
         default: return 16'(int'($urandom_range(65534, 0)) - 32767);
      endcase
   endfunction

   function automatic logic [7:0] random_char();
      int idx;
      if ($urandom_range(9, 0) < 3) return 8'($urandom);
      idx = $urandom_range(11, 0);
      if (idx == 0) return CH_PLUS;
      if (idx == 1) return CH_MINUS;
      return CH_ZERO + 8'(idx - 2);
   endfunction

   function automatic void queue_random_draw();
      int pick;
      logic [3:0] page;
      logic [6:0] shift;
      pick  = $urandom_range(99, 0);
      page  = ($urandom_range(9, 0) < 8) ? 4'($urandom_range(7, 0)) : 4'($urandom_range(15, 8));
      shift = ($urandom_range(9, 0) < 7) ? 7'($urandom_range(93, 0))
                                         : 7'($urandom_range(127, 94));
      if (pick < 4) begin
         queue_plain(CMD_CLEAR);
      end else if (pick < 45) begin
         queue_cmd(CMD_NUMBER, random_number(), 8'($urandom), 4'($urandom), 7'($urandom));
      end else begin
         queue_cmd(CMD_SYMBOL, 16'($urandom), random_char(), page, shift);
      end
   endfunction

   // hold the sender until every byte is back and any trailing clear is done
   task automatic wait_idle();
      while (cmd_backlog.size() != 0 || drv_busy || bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_column(input logic [7:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= START_COL_ADDR;
      pwdata  <= {24'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      col_addr_reg = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // draw runs followed by emit runs
   task automatic run_random_phase(input int tx_pct, input int rx_pct);
      int items;
      int burst;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      items = 0;
      while (items < PHASE_ITEMS) begin
         repeat ($urandom_range(12, 1)) begin
            queue_random_draw();
            items++;
         end
         burst = $urandom_range(24, 1);
         repeat (burst) queue_plain(CMD_EMIT);
         items += burst;
      end
      wait_idle();
   endtask

   initial begin
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_bus.valid        = 1'b0;
      req_bus.command      = CMD_CLEAR;
      req_bus.number       = '0;
      req_bus.char_code    = '0;
      req_bus.page_index   = '0;
      req_bus.column_shift = '0;
      rsp_bus.ready        = 1'b0;
      clear_panel();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // header bytes of page 0 with the reset start column and an empty store
      repeat (3) queue_plain(CMD_EMIT);
      queue_cmd(CMD_SYMBOL, 16'h0, CH_ZERO + 8'd8, 4'd0, 7'd0);
      queue_cmd(CMD_SYMBOL, 16'h0, CH_PLUS, 4'd0, 7'd93);
      // partly past the left edge, then entirely past it
      queue_cmd(CMD_SYMBOL, 16'h0, CH_MINUS, 4'd0, 7'd100);
      queue_cmd(CMD_SYMBOL, 16'h0, CH_ZERO, 4'd0, 7'd127);
      // unknown characters
      queue_cmd(CMD_SYMBOL, 16'h0, 8'hFF, 4'd1, 7'd5);
      queue_cmd(CMD_SYMBOL, 16'h0, 8'h00, 4'd2, 7'd0);
      // pages beyond the store
      queue_cmd(CMD_SYMBOL, 16'h0, CH_ZERO + 8'd5, 4'd8, 7'd0);
      queue_cmd(CMD_SYMBOL, 16'h0, CH_ZERO + 8'd9, 4'd15, 7'd93);
      repeat (5) queue_plain(CMD_EMIT);
      queue_cmd(CMD_NUMBER, 16'h7FFF, 8'h00, 4'd0, 7'd0);
      queue_cmd(CMD_NUMBER, 16'h8000, 8'hFF, 4'hF, 7'h7F);
      queue_cmd(CMD_NUMBER, 16'h0000, 8'h00, 4'd0, 7'd0);
      queue_cmd(CMD_NUMBER, 16'hFFFF, 8'hFF, 4'hF, 7'h7F);
      queue_plain(CMD_CLEAR);
      queue_cmd(CMD_SYMBOL, 16'h0, CH_ZERO + 8'd7, 4'd0, 7'd1);
      repeat (3) queue_plain(CMD_EMIT);
      wait_idle();

      write_start_column(8'd0);
      run_random_phase(15, 15);

      write_start_column(8'd255);
      hold_go = 1'b1;
      run_random_phase(5, 30);

      write_start_column(8'd131);
      run_random_phase(30, 5);

      write_start_column(8'($urandom));
      run_random_phase(10, 10);

      // closing stretch with no idling on either side
      write_start_column(8'($urandom));
      run_random_phase(0, 0);

      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
